/* sv/i2cram_pkg.sv */
// shared types and constants of the i2c register access master
// holds request codes, sequencer step codes and the result layout; no dependencies
`default_nettype none

package i2cram_pkg;

    // field widths
    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int DEV_W     = 7;
    localparam int STEP_W    = 4;
    localparam int QPHASE_W  = 2;
    localparam int BITCNT_W  = 3;
    localparam int IN_DATA_W = 32;
    localparam int OUT_W     = 16;

    // device address after reset
    localparam logic [DEV_W-1:0] TARGET_ADDR_RESET = 7'd118;

    // request operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // sequencer steps, byte steps are followed directly by their ack step
    localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] ST_START    = 4'd1;
    localparam logic [STEP_W-1:0] ST_ADDR     = 4'd2;
    localparam logic [STEP_W-1:0] ST_ACK_ADDR = 4'd3;
    localparam logic [STEP_W-1:0] ST_REG      = 4'd4;
    localparam logic [STEP_W-1:0] ST_ACK_REG  = 4'd5;
    localparam logic [STEP_W-1:0] ST_WDATA    = 4'd6;
    localparam logic [STEP_W-1:0] ST_ACK_DATA = 4'd7;
    localparam logic [STEP_W-1:0] ST_STOP     = 4'd8;
    localparam logic [STEP_W-1:0] ST_RSTART   = 4'd9;
    localparam logic [STEP_W-1:0] ST_RADDR    = 4'd10;
    localparam logic [STEP_W-1:0] ST_RACK     = 4'd11;
    localparam logic [STEP_W-1:0] ST_RDATA    = 4'd12;
    localparam logic [STEP_W-1:0] ST_MACK     = 4'd13;
    localparam logic [STEP_W-1:0] ST_RSTOP    = 4'd14;

    // result word, listed from the highest bit down
    typedef struct packed {
        logic              command_rejected;
        logic              busy_res;
        logic              done_res;
        logic              ack_error;
        logic [BYTE_W-1:0] read_data;
        logic              read_valid;
        logic              data_taken;
        logic              sda_drive_low;
        logic              scl_drive_low;
    } t_result;

endpackage

`default_nettype wire

/* sv/i2c_register_access_master_core.sv */
// i2c register access master: command latch, quarter-bit sequencer and result register
// depends on i2cram_pkg for codes and the result layout
`default_nettype none

// Usage
//   The slave stream carries requests: tuser holds the operation (tick, start write,
//   start read), tdata the register byte, byte count, next write byte and sampled SDA.
//   A command latches a transaction; each following tick advances it by one quarter
//   of an SCL bit and reports the SCL and SDA drives as they stand afterwards.
//   Every request yields exactly one result on the master stream.
//   The result becomes valid in the cycle after the request is accepted; a request can be
//   taken every cycle while the result register is free or being read, since the whole step
//   is one pass of logic between the state registers and the result register.
//   When the receiver stalls, the result register holds its word and tready stays
//   high only if that word is being taken in the same cycle, so nothing is lost.
//   The device address is written through i_cfg_wr_en / i_cfg_wr_data; the user must
//   do so only while idle, as the block does not check it. Synchronous reset (i_rst_n
//   low) returns the sequencer to idle, releases both pins, clears the error flag,
//   empties the result register and sets the device address back to its default.
module i2c_register_access_master_core
    import i2cram_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [DEV_W-1:0]     i_cfg_wr_data,
    // request stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata: register_address[7:0], byte_count[15:8], write_data[23:16], sda_level[24]
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    // tuser: operation[1:0]
    input  wire logic [OP_W-1:0]      s_axis_tuser,
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // tdata: scl_drive_low[0], sda_drive_low[1], data_taken[2], read_valid[3],
    //        read_data[11:4], ack_error[12], done_res[13], busy_res[14],
    //        command_rejected[15]
    output logic [OUT_W-1:0]          m_axis_tdata
);

    // request fields
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] in_reg;
    logic [BYTE_W-1:0] in_count;
    logic [BYTE_W-1:0] in_wdata;
    logic              in_sda;
    logic              accept;

    assign op       = s_axis_tuser;
    assign in_reg   = s_axis_tdata[7:0];
    assign in_count = s_axis_tdata[15:8];
    assign in_wdata = s_axis_tdata[23:16];
    assign in_sda   = s_axis_tdata[24];

    // state registers
    logic [DEV_W-1:0]    r_target_addr;
    logic [STEP_W-1:0]   r_step,  n_step;
    logic [QPHASE_W-1:0] r_qph,   n_qph;
    logic [BITCNT_W-1:0] r_bcnt,  n_bcnt;
    logic [BYTE_W-1:0]   r_shift, n_shift;
    logic [BYTE_W-1:0]   r_left,  n_left;
    logic [BYTE_W-1:0]   r_sreg,  n_sreg;
    logic                r_is_rd, n_is_rd;
    logic                r_ack,   n_ack;
    logic                r_scl,   n_scl;
    logic                r_sda,   n_sda;

    // result register
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    // per-step temporaries
    logic [BYTE_W-1:0] shift_src;
    logic [BYTE_W-1:0] rx_byte;
    logic [BYTE_W-1:0] left_dec;
    logic              tx_one;
    logic              taken;
    logic              rvalid;
    logic              done;
    logic              rejected;

    // result register frees up when empty or being taken
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // sequencer next state
    always_comb begin
        n_step    = r_step;
        n_qph     = r_qph;
        n_bcnt    = r_bcnt;
        n_shift   = r_shift;
        n_left    = r_left;
        n_sreg    = r_sreg;
        n_is_rd   = r_is_rd;
        n_ack     = r_ack;
        n_scl     = r_scl;
        n_sda     = r_sda;
        taken     = 1'b0;
        rvalid    = 1'b0;
        done      = 1'b0;
        rejected  = 1'b0;
        shift_src = r_shift;
        rx_byte   = {r_shift[BYTE_W-2:0], in_sda};
        left_dec  = r_left - 8'd1;
        tx_one    = 1'b0;

        if (op == OP_WRITE || op == OP_READ) begin
            // command: latch when idle, reject otherwise
            if (r_step != ST_IDLE) begin
                rejected = 1'b1;
            end else begin
                n_sreg  = in_reg;
                n_left  = in_count;
                n_is_rd = (op == OP_READ);
                n_ack   = 1'b0;
                n_step  = ST_START;
                n_qph   = '0;
                n_bcnt  = '0;
            end
        end else if (op == OP_TICK && r_step != ST_IDLE) begin
            case (r_step)
                // start condition: release sda, release scl, pull sda
                ST_START, ST_RSTART: begin
                    if (r_qph == 2'd0) begin
                        n_sda = 1'b0;
                    end else if (r_qph == 2'd1) begin
                        n_scl = 1'b0;
                    end else begin
                        n_sda = 1'b1;
                    end
                    if (r_qph[1]) begin
                        n_step = (r_step == ST_START) ? ST_ADDR : ST_RADDR;
                        n_qph  = '0;
                        n_bcnt = '0;
                    end else begin
                        n_qph = r_qph + 2'd1;
                    end
                end
                // sent byte, loaded on its first quarter
                ST_ADDR, ST_REG, ST_WDATA, ST_RADDR: begin
                    if (r_qph == 2'd0 && r_bcnt == 3'd0) begin
                        case (r_step)
                            ST_ADDR:  shift_src = {r_target_addr, 1'b0};
                            ST_RADDR: shift_src = {r_target_addr, 1'b1};
                            ST_REG:   shift_src = r_sreg;
                            default: begin
                                shift_src = in_wdata;
                                taken     = 1'b1;
                            end
                        endcase
                    end
                    n_shift = shift_src;
                    tx_one  = shift_src[BYTE_W-1];
                    if (r_qph == 2'd0) begin
                        n_scl = 1'b1;
                        n_qph = r_qph + 2'd1;
                    end else if (r_qph == 2'd1) begin
                        n_sda = !tx_one;
                        n_qph = r_qph + 2'd1;
                    end else if (r_qph == 2'd2) begin
                        n_scl = 1'b0;
                        n_qph = r_qph + 2'd1;
                    end else begin
                        n_shift = {shift_src[BYTE_W-2:0], 1'b0};
                        n_qph   = '0;
                        if (r_bcnt == 3'd7) begin
                            n_step = r_step + 4'd1;
                            n_bcnt = '0;
                        end else begin
                            n_bcnt = r_bcnt + 3'd1;
                        end
                    end
                end
                // acknowledge from the target, sampled in the fourth quarter
                ST_ACK_ADDR, ST_ACK_REG, ST_ACK_DATA, ST_RACK: begin
                    if (r_qph == 2'd0) begin
                        n_scl = 1'b1;
                        n_sda = 1'b0;
                        n_qph = r_qph + 2'd1;
                    end else if (r_qph == 2'd1) begin
                        n_qph = r_qph + 2'd1;
                    end else if (r_qph == 2'd2) begin
                        n_scl = 1'b0;
                        n_qph = r_qph + 2'd1;
                    end else begin
                        n_ack  = r_ack | in_sda;
                        n_qph  = '0;
                        n_bcnt = '0;
                        case (r_step)
                            ST_ACK_ADDR: n_step = ST_REG;
                            ST_ACK_REG: begin
                                n_step = (r_is_rd || r_left == 8'd0) ? ST_STOP : ST_WDATA;
                            end
                            ST_ACK_DATA: begin
                                n_left = left_dec;
                                n_step = (left_dec == 8'd0) ? ST_STOP : ST_WDATA;
                            end
                            default: n_step = (r_left == 8'd0) ? ST_MACK : ST_RDATA;
                        endcase
                    end
                end
                // received data bit
                ST_RDATA: begin
                    if (r_qph == 2'd0) begin
                        n_scl = 1'b1;
                        n_sda = 1'b0;
                        n_qph = r_qph + 2'd1;
                    end else if (r_qph == 2'd1) begin
                        n_qph = r_qph + 2'd1;
                    end else if (r_qph == 2'd2) begin
                        n_scl = 1'b0;
                        n_qph = r_qph + 2'd1;
                    end else begin
                        n_shift = rx_byte;
                        n_qph   = '0;
                        if (r_bcnt == 3'd7) begin
                            rvalid = 1'b1;
                            if (r_left != 8'd0) begin
                                n_left = left_dec;
                            end
                            n_step = ST_MACK;
                            n_bcnt = '0;
                        end else begin
                            n_bcnt = r_bcnt + 3'd1;
                        end
                    end
                end
                // master ack after a byte, nack after the last one
                ST_MACK: begin
                    tx_one = (r_left == 8'd0);
                    if (r_qph == 2'd0) begin
                        n_scl = 1'b1;
                        n_qph = r_qph + 2'd1;
                    end else if (r_qph == 2'd1) begin
                        n_sda = !tx_one;
                        n_qph = r_qph + 2'd1;
                    end else if (r_qph == 2'd2) begin
                        n_scl = 1'b0;
                        n_qph = r_qph + 2'd1;
                    end else begin
                        n_step = (r_left != 8'd0) ? ST_RDATA : ST_RSTOP;
                        n_qph  = '0;
                        n_bcnt = '0;
                    end
                end
                // stop condition: pull both, release scl, release sda
                ST_STOP, ST_RSTOP: begin
                    if (r_qph == 2'd0) begin
                        n_scl = 1'b1;
                        n_sda = 1'b1;
                    end else if (r_qph == 2'd1) begin
                        n_scl = 1'b0;
                    end else begin
                        n_sda = 1'b0;
                    end
                    if (r_qph[1]) begin
                        n_qph  = '0;
                        n_bcnt = '0;
                        if (r_step == ST_STOP && r_is_rd) begin
                            n_step = ST_RSTART;
                        end else begin
                            n_step = ST_IDLE;
                            done   = 1'b1;
                        end
                    end else begin
                        n_qph = r_qph + 2'd1;
                    end
                end
                default: begin
                    n_step = ST_IDLE;
                    n_qph  = '0;
                    n_bcnt = '0;
                    n_scl  = 1'b0;
                    n_sda  = 1'b0;
                end
            endcase
        end
    end

    // result word for this request
    always_comb begin
        n_out.scl_drive_low    = n_scl;
        n_out.sda_drive_low    = n_sda;
        n_out.data_taken       = taken;
        n_out.read_valid       = rvalid;
        n_out.read_data        = rvalid ? rx_byte : 8'd0;
        n_out.ack_error        = n_ack;
        n_out.done_res         = done;
        n_out.busy_res         = (n_step != ST_IDLE);
        n_out.command_rejected = rejected;
    end

    // device address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_addr <= TARGET_ADDR_RESET;
        end else if (i_cfg_wr_en) begin
            r_target_addr <= i_cfg_wr_data;
        end
    end

    // sequencer state, advanced once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_IDLE;
            r_qph   <= '0;
            r_bcnt  <= '0;
            r_shift <= '0;
            r_left  <= '0;
            r_sreg  <= '0;
            r_is_rd <= 1'b0;
            r_ack   <= 1'b0;
            r_scl   <= 1'b0;
            r_sda   <= 1'b0;
        end else if (accept) begin
            r_step  <= n_step;
            r_qph   <= n_qph;
            r_bcnt  <= n_bcnt;
            r_shift <= n_shift;
            r_left  <= n_left;
            r_sreg  <= n_sreg;
            r_is_rd <= n_is_rd;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    // a finished transaction never reports itself busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.busy_res)
        else $error("done result reports busy");

    // a rejected command leaves the sequencer where it was
    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (op == OP_WRITE || op == OP_READ) && r_step != ST_IDLE
        |=> r_step == $past(r_step) && r_qph == $past(r_qph))
        else $error("rejected command moved the sequencer");

    // a completed read byte is always followed by the master ack bit
    a_rvalid_to_mack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && rvalid |=> r_step == ST_MACK && r_qph == 2'd0)
        else $error("read byte not followed by master ack");

    // start and stop take three quarters only
    a_cond_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_START || r_step == ST_RSTART || r_step == ST_STOP ||
         r_step == ST_RSTOP) |-> r_qph != 2'd3)
        else $error("start or stop past its third quarter");

    // the bit counter runs only inside data bytes
    a_bcnt_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcnt != 3'd0 |-> (r_step == ST_ADDR || r_step == ST_REG ||
         r_step == ST_WDATA || r_step == ST_RADDR || r_step == ST_RDATA))
        else $error("bit counter set outside a byte");

endmodule

`default_nettype wire

/* tb/tb_i2c_register_access_master_core.sv */
// self-checking testbench for the i2c register access master core
// predicts every result word from the request stream and checks it; depends on i2cram_pkg
`default_nettype none

module tb_i2c_register_access_master_core
    import i2cram_pkg::*;
();

    // the fourth operation code has no meaning and must be ignored
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD = 300;

    // bus-level model of the sequencer plus the queue of results it still owes
    class i2c_pin_tracker;
        logic [DEV_W-1:0]    target_addr;
        logic [STEP_W-1:0]   step;
        logic [QPHASE_W-1:0] qph;
        logic [BITCNT_W-1:0] bitc;
        logic [BYTE_W-1:0]   shreg;
        logic [BYTE_W-1:0]   left;
        logic [BYTE_W-1:0]   reg_saved;
        logic                rd;
        logic                ackacc;
        logic                scl_low;
        logic                sda_low;
        t_result             awaited[$];
        int n_requests, n_results, n_done, n_rejected, n_taken, n_read_bytes, errors;

        function new();
            target_addr = TARGET_ADDR_RESET;
            step = ST_IDLE;
            qph = '0;
            bitc = '0;
            shreg = '0;
            left = '0;
            reg_saved = '0;
            rd = 1'b0;
            ackacc = 1'b0;
            scl_low = 1'b0;
            sda_low = 1'b0;
            n_requests = 0;
            n_results = 0;
            n_done = 0;
            n_rejected = 0;
            n_taken = 0;
            n_read_bytes = 0;
            errors = 0;
        endfunction

        function void go(logic [STEP_W-1:0] nxt);
            step = nxt;
            qph = '0;
            bitc = '0;
        endfunction

        // one quarter of a sent bit, true on the hold quarter
        function bit tx_quarter(bit one);
            case (qph)
                2'd0: scl_low = 1'b1;
                2'd1: sda_low = !one;
                2'd2: scl_low = 1'b0;
                default: return 1'b1;
            endcase
            qph = qph + 2'd1;
            return 1'b0;
        endfunction

        // one quarter of a received bit, true on the sampling quarter
        function bit rx_quarter();
            case (qph)
                2'd0: begin
                    scl_low = 1'b1;
                    sda_low = 1'b0;
                end
                2'd2: scl_low = 1'b0;
                2'd3: return 1'b1;
                default: ;
            endcase
            qph = qph + 2'd1;
            return 1'b0;
        endfunction

        // advance the model by one accepted request and queue the result it owes
        function void note_request(logic [OP_W-1:0] op, logic [IN_DATA_W-1:0] word);
            t_result r;
            logic [BYTE_W-1:0] reg_b, cnt_b, wd_b;
            logic sda_b;
            logic [STEP_W-1:0] s;
            r = '0;
            reg_b = word[7:0];
            cnt_b = word[15:8];
            wd_b = word[23:16];
            sda_b = word[24];
            s = step;
            n_requests++;
            if (op == OP_WRITE || op == OP_READ) begin
                if (s != ST_IDLE) begin
                    r.command_rejected = 1'b1;
                    n_rejected++;
                end else begin
                    reg_saved = reg_b;
                    left = cnt_b;
                    rd = (op == OP_READ);
                    ackacc = 1'b0;
                    go(ST_START);
                end
            end else if (op == OP_TICK && s != ST_IDLE) begin
                case (s)
                    ST_START, ST_RSTART: begin
                        if (qph == 2'd0) sda_low = 1'b0;
                        else if (qph == 2'd1) scl_low = 1'b0;
                        else sda_low = 1'b1;
                        if (qph >= 2'd2) go(s == ST_START ? ST_ADDR : ST_RADDR);
                        else qph = qph + 2'd1;
                    end
                    ST_ADDR, ST_REG, ST_WDATA, ST_RADDR: begin
                        // load the byte on its first quarter
                        if (qph == 2'd0 && bitc == 3'd0) begin
                            case (s)
                                ST_ADDR:  shreg = {target_addr, 1'b0};
                                ST_RADDR: shreg = {target_addr, 1'b1};
                                ST_REG:   shreg = reg_saved;
                                default: begin
                                    shreg = wd_b;
                                    r.data_taken = 1'b1;
                                end
                            endcase
                        end
                        if (tx_quarter(shreg[7])) begin
                            shreg = {shreg[6:0], 1'b0};
                            if (bitc >= 3'd7) go(s + 4'd1);
                            else begin
                                bitc = bitc + 3'd1;
                                qph = '0;
                            end
                        end
                    end
                    ST_ACK_ADDR, ST_ACK_REG, ST_ACK_DATA, ST_RACK: begin
                        if (rx_quarter()) begin
                            ackacc = ackacc | sda_b;
                            if (s == ST_ACK_ADDR) go(ST_REG);
                            else if (s == ST_ACK_REG)
                                go((rd || left == 8'd0) ? ST_STOP : ST_WDATA);
                            else if (s == ST_ACK_DATA) begin
                                left = left - 8'd1;
                                go(left == 8'd0 ? ST_STOP : ST_WDATA);
                            end else
                                go(left == 8'd0 ? ST_MACK : ST_RDATA);
                        end
                    end
                    ST_RDATA: begin
                        if (rx_quarter()) begin
                            shreg = {shreg[6:0], sda_b};
                            if (bitc >= 3'd7) begin
                                r.read_valid = 1'b1;
                                r.read_data = shreg;
                                if (left != 8'd0) left = left - 8'd1;
                                go(ST_MACK);
                            end else begin
                                bitc = bitc + 3'd1;
                                qph = '0;
                            end
                        end
                    end
                    ST_MACK: begin
                        // ack between bytes, nack after the last
                        if (tx_quarter(left == 8'd0))
                            go(left != 8'd0 ? ST_RDATA : ST_RSTOP);
                    end
                    ST_STOP, ST_RSTOP: begin
                        if (qph == 2'd0) begin
                            scl_low = 1'b1;
                            sda_low = 1'b1;
                        end else if (qph == 2'd1) scl_low = 1'b0;
                        else sda_low = 1'b0;
                        if (qph >= 2'd2) begin
                            if (s == ST_STOP && rd) go(ST_RSTART);
                            else begin
                                go(ST_IDLE);
                                r.done_res = 1'b1;
                            end
                        end else qph = qph + 2'd1;
                    end
                    default: begin
                        go(ST_IDLE);
                        scl_low = 1'b0;
                        sda_low = 1'b0;
                    end
                endcase
            end
            r.scl_drive_low = scl_low;
            r.sda_drive_low = sda_low;
            r.ack_error = ackacc;
            r.busy_res = (step != ST_IDLE);
            if (r.done_res) n_done++;
            if (r.data_taken) n_taken++;
            if (r.read_valid) n_read_bytes++;
            awaited.push_back(r);
        endfunction

        function void compare(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void compare_flag(string name, logic want, logic got);
            if (want !== got) begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // match one result word against the oldest outstanding prediction
        function void check_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                $error("result %h arrived with no request outstanding", got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            n_results++;
            compare_flag("scl_drive_low", want.scl_drive_low, got.scl_drive_low);
            compare_flag("sda_drive_low", want.sda_drive_low, got.sda_drive_low);
            compare_flag("data_taken", want.data_taken, got.data_taken);
            compare_flag("read_valid", want.read_valid, got.read_valid);
            compare("read_data", want.read_data, got.read_data);
            compare_flag("ack_error", want.ack_error, got.ack_error);
            compare_flag("done_res", want.done_res, got.done_res);
            compare_flag("busy_res", want.busy_res, got.busy_res);
            compare_flag("command_rejected", want.command_rejected, got.command_rejected);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [DEV_W-1:0]     i_cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [OP_W-1:0]      s_axis_tuser = OP_TICK;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;

    i2c_pin_tracker sb = new();
    int gap_pct = 0;
    int stall_pct = 0;
    bit long_hold_req = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;
    int addr_writes = 0;

    i2c_register_access_master_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side: random stalls plus an occasional long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // result checking and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_result(t_result'(m_axis_tdata));
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // offer one request, return in the cycle it is accepted with valid still high
    task automatic send_request(input logic [OP_W-1:0] op, input logic [7:0] reg_b,
                                input logic [7:0] cnt_b, input logic [7:0] wd_b,
                                input logic sda_b);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[7:0] = reg_b;
        word[15:8] = cnt_b;
        word[23:16] = wd_b;
        word[24] = sda_b;
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, word);
    endtask

    // ack quarters get high sda at the given nack percentage, everything else is random
    function automatic logic pick_sda(int nack_pct);
        if (sb.step == ST_ACK_ADDR || sb.step == ST_ACK_REG ||
            sb.step == ST_ACK_DATA || sb.step == ST_RACK)
            return ($urandom_range(99) < nack_pct);
        return 1'($urandom_range(1));
    endfunction

    // tick the bus until the sequencer is idle, with some stray requests mixed in
    task automatic finish_transaction(input int nack_pct);
        int pick;
        while (sb.step != ST_IDLE) begin
            pick = $urandom_range(99);
            if (pick < 3)
                send_request(OP_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 1'($urandom_range(1)));
            else if (pick < 6)
                send_request(OP_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 1'($urandom_range(1)));
            else if (pick < 8)
                send_request(OP_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 1'($urandom_range(1)));
            else
                send_request(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), pick_sda(nack_pct));
        end
    endtask

    task automatic run_transaction(input bit is_rd, input logic [7:0] reg_b,
                                   input logic [7:0] cnt_b, input int nack_pct);
        send_request(is_rd ? OP_READ : OP_WRITE, reg_b, cnt_b, 8'($urandom_range(255)),
                     1'($urandom_range(1)));
        finish_transaction(nack_pct);
    endtask

    // drop valid and wait for every outstanding result
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_device_address(input logic [DEV_W-1:0] addr);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= addr;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.target_addr = addr;
        addr_writes++;
    endtask

    initial begin
        int gap_tab[4];
        int stall_tab[4];
        logic [DEV_W-1:0] addr_tab[4];
        bit rd_tab[4];
        logic [7:0] cnt_tab[4];
        gap_tab = '{0, 81, 0, 9};
        stall_tab = '{0, 0, 81, 9};
        addr_tab = '{7'h00, 7'h7F, 7'h00, 7'h2A};
        addr_tab[2] = 7'($urandom_range(127));
        // multi-byte read and write, zero-length read, then a random short one
        rd_tab = '{1'b1, 1'b0, 1'b1, 1'b0};
        cnt_tab = '{8'd2, 8'd2, 8'd0, 8'd0};
        rd_tab[3] = 1'($urandom_range(1));
        cnt_tab[3] = 8'($urandom_range(1));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle ticks, unused code, zero-length write with rejected commands
        send_request(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_request(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        send_request(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_request(OP_UNUSED, 8'h00, 8'h00, 8'h00, 1'b0);
        send_request(OP_WRITE, 8'hFF, 8'h00, 8'h00, 1'b0);
        send_request(OP_READ, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_request(OP_WRITE, 8'h00, 8'h00, 8'h00, 1'b0);
        send_request(OP_UNUSED, 8'h5A, 8'hA5, 8'h3C, 1'b1);
        finish_transaction(100);
        wait_drained();

        // one transaction under each flow-control profile
        for (int ph = 0; ph < 4; ph++) begin
            write_device_address(addr_tab[ph]);
            gap_pct = gap_tab[ph];
            stall_pct = stall_tab[ph];
            if (ph == 0) long_hold_req = 1'b1;
            if ($urandom_range(4) == 0)
                send_request($urandom_range(1) ? OP_TICK : OP_UNUSED,
                             8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 1'($urandom_range(1)));
            run_transaction(rd_tab[ph], 8'($urandom_range(255)), cnt_tab[ph], 10);
            wait_drained();
        end

        stall_pct = 0;
        repeat (10) @(posedge i_clk);
        if (sb.awaited.size() != 0) begin
            $error("%0d results never arrived", sb.awaited.size());
            sb.errors++;
        end
        $display("run: %0d requests, %0d transactions completed, %0d commands refused",
                 sb.n_requests, sb.n_done, sb.n_rejected);
        $display("run: %0d bytes written, %0d bytes read, %0d device address writes",
                 sb.n_taken, sb.n_read_bytes, addr_writes);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* i2c_register_access_master_core.f */
sv/i2cram_pkg.sv
sv/i2c_register_access_master_core.sv
tb/tb_i2c_register_access_master_core.sv
